### rtl/dslg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dslg_pkg
// Shared constants and controller/datapath handshake types for the seeded
// djb2 / LCG string generator.
// ----------------------------------------------------------------------------
package dslg_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CHAR_W   = 7;
    localparam int unsigned LEN_W    = 6;
    localparam int unsigned HASH_W   = 32;

    localparam logic [HASH_W-1:0] HASH_INIT = 32'd5381;
    localparam logic [HASH_W-1:0] LCG_INIT  = 32'd1;
    localparam logic [HASH_W-1:0] LCG_MUL   = 32'd1103515245;
    localparam logic [HASH_W-1:0] LCG_ADD   = 32'd12345;
    localparam logic [LEN_W-1:0]  LEN_RESET = 6'd16;
    localparam logic [CHAR_W-1:0] CHAR_BASE = 7'd33;

    // Remainder by 94 of a 15-bit value: q = (v * RECIP) >> RECIP_SH.
    localparam int unsigned       MOD_IN_W  = 15;
    localparam int unsigned       RECIP_W   = 16;
    localparam int unsigned       RECIP_SH  = 22;
    localparam int unsigned       QUOT_W    = 9;
    localparam logic [RECIP_W-1:0] RECIP    = 16'd44621;
    localparam logic [MOD_IN_W-1:0] CHAR_SPAN = 15'd94;

    // Controller -> datapath commands.
    typedef struct packed {
        logic absorb;     // fold the input byte into the hash
        logic seed;       // load the LCG from the hash, restart hash and count
        logic lcg_adv;    // step the LCG once
        logic mod_mul;    // register the reciprocal product
        logic load_char;  // load a character into the output register
        logic load_term;  // load the terminator into the output register
    } t_cmd;

    // Datapath -> controller status.
    typedef struct packed {
        logic byte_zero;  // input byte is the string terminator
        logic cnt_done;   // all characters of this string loaded
        logic out_full;   // output register cannot take a new item
    } t_stat;

endpackage
`default_nettype wire

### rtl/dslg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dslg_if
// Valid/ready channels of the string generator: input bytes, output
// characters and the length configuration write.
// ----------------------------------------------------------------------------
interface dslg_in_if;
    logic                            valid;
    logic                            ready;
    logic [dslg_pkg::BYTE_W-1:0]     in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface dslg_out_if;
    logic                            valid;
    logic                            ready;
    logic [dslg_pkg::CHAR_W-1:0]     out_char;
    logic                            last;
    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

interface dslg_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dslg_pkg::LEN_W-1:0]      out_length;
    modport source (output valid, output out_length, input ready);
    modport sink   (input valid, input out_length, output ready);
endinterface
`default_nettype wire

### rtl/dslg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dslg_ctrl
// Sequencer: absorb bytes, then step LCG / reduce / load for each character
// and finish with the terminator.
// ----------------------------------------------------------------------------
module dslg_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire dslg_pkg::t_stat i_stat,
    output dslg_pkg::t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_STEP = 5'b00010,
        S_MUL  = 5'b00100,
        S_LOAD = 5'b01000,
        S_TERM = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_stat.byte_zero) begin
                        o_cmd.seed = 1'b1;
                        n_state    = S_STEP;
                    end else begin
                        o_cmd.absorb = 1'b1;
                    end
                end
            end
            S_STEP: begin
                if (i_stat.cnt_done) begin
                    n_state = S_TERM;
                end else begin
                    o_cmd.lcg_adv = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mod_mul = 1'b1;
                n_state       = S_LOAD;
            end
            S_LOAD: begin
                // hold until the output register frees up
                if (!i_stat.out_full) begin
                    o_cmd.load_char = 1'b1;
                    n_state         = S_STEP;
                end
            end
            S_TERM: begin
                if (!i_stat.out_full) begin
                    o_cmd.load_term = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

### rtl/dslg_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dslg_dp
// Datapath: hash accumulator, LCG state, mod-94 reduction, emit counter,
// length register and output register.
// ----------------------------------------------------------------------------
module dslg_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [dslg_pkg::BYTE_W-1:0]   i_byte,
    input  wire logic                          i_cfg_we,
    input  wire logic [dslg_pkg::LEN_W-1:0]    i_cfg_len,
    input  wire dslg_pkg::t_cmd                i_cmd,
    output dslg_pkg::t_stat                    o_stat,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [dslg_pkg::CHAR_W-1:0]        o_out_char,
    output logic                               o_out_last
);

    localparam int unsigned PROD_W = dslg_pkg::MOD_IN_W + dslg_pkg::RECIP_W;

    logic [dslg_pkg::HASH_W-1:0]   r_hash;
    logic [dslg_pkg::HASH_W-1:0]   n_hash;
    logic [dslg_pkg::HASH_W-1:0]   r_lcg;
    logic [dslg_pkg::HASH_W-1:0]   n_lcg;
    logic [dslg_pkg::LEN_W-1:0]    r_len;
    logic [dslg_pkg::LEN_W-1:0]    r_cnt;
    logic [dslg_pkg::MOD_IN_W-1:0] r_v;
    logic [PROD_W-1:0]             r_prod;
    logic                          r_out_valid;
    logic [dslg_pkg::CHAR_W-1:0]   r_out_char;
    logic                          r_out_last;

    logic [dslg_pkg::HASH_W-1:0]   sext_byte;
    logic [dslg_pkg::MOD_IN_W-1:0] v_now;
    logic [dslg_pkg::QUOT_W-1:0]   quot;
    logic [dslg_pkg::MOD_IN_W-1:0] quot_x94;
    logic [dslg_pkg::MOD_IN_W-1:0] rem_raw;
    logic [dslg_pkg::MOD_IN_W-1:0] rem_fix;
    logic [dslg_pkg::CHAR_W-1:0]   char_val;

    // hash * 33 + sign-extended byte
    assign sext_byte = {{(dslg_pkg::HASH_W-dslg_pkg::BYTE_W){i_byte[dslg_pkg::BYTE_W-1]}},
                        i_byte};
    assign n_hash    = {r_hash[dslg_pkg::HASH_W-6:0], 5'b0} + r_hash + sext_byte;
    assign n_lcg     = r_lcg * dslg_pkg::LCG_MUL + dslg_pkg::LCG_ADD;

    assign v_now     = r_lcg[30:16];
    assign quot      = r_prod[PROD_W-1:dslg_pkg::RECIP_SH];
    // quot * 94 = quot * 64 + quot * 32 - quot * 2
    assign quot_x94  = ({6'b0, quot} << 6) + ({6'b0, quot} << 5) - ({6'b0, quot} << 1);
    assign rem_raw   = r_v - quot_x94;
    assign rem_fix   = (rem_raw >= dslg_pkg::CHAR_SPAN) ? rem_raw - dslg_pkg::CHAR_SPAN
                                                        : rem_raw;
    assign char_val  = rem_fix[dslg_pkg::CHAR_W-1:0] + dslg_pkg::CHAR_BASE;

    assign o_stat.byte_zero = (i_byte == '0);
    assign o_stat.cnt_done  = (r_cnt == r_len);
    assign o_stat.out_full  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= dslg_pkg::HASH_INIT;
            r_lcg       <= dslg_pkg::LCG_INIT;
            r_len       <= dslg_pkg::LEN_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_len;
            end
            if (i_cmd.absorb) begin
                r_hash <= n_hash;
            end
            if (i_cmd.seed) begin
                r_lcg  <= r_hash;
                r_hash <= dslg_pkg::HASH_INIT;
                r_cnt  <= '0;
            end
            if (i_cmd.lcg_adv) begin
                r_lcg <= n_lcg;
            end
            if (i_cmd.load_char) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.load_char || i_cmd.load_term) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_mul) begin
            r_v    <= v_now;
            r_prod <= v_now * dslg_pkg::RECIP;
        end
        if (i_cmd.load_char) begin
            r_out_char <= char_val;
            r_out_last <= 1'b0;
        end else if (i_cmd.load_term) begin
            r_out_char <= '0;
            r_out_last <= 1'b1;
        end
    end

endmodule
`default_nettype wire

### rtl/djb2_seeded_lcg_string_gen_unit.sv
`default_nettype none
// A nonzero byte is absorbed in the cycle it is accepted, one byte per cycle while the
// sequencer is idle. A zero byte yields out_length characters, each through an LCG step,
// reciprocal multiply, remainder and output load, then the terminator after the last one.
// Input is held off from the zero byte until the terminator is loaded; each load waits
// while the output register is full. Reset (synchronous, active low): hash 5381, LCG 1,
// out_length 16, output empty.
// ----------------------------------------------------------------------------
// djb2_seeded_lcg_string_gen_unit
// Hashes an input string with djb2 and expands the hash through the ANSI C
// LCG into a printable string ending in a zero terminator.
// ----------------------------------------------------------------------------
module djb2_seeded_lcg_string_gen_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dslg_in_if.sink    i_in,
    dslg_out_if.source o_out,
    dslg_cfg_if.sink   i_cfg
);

    dslg_pkg::t_cmd  cmd;
    dslg_pkg::t_stat stat;

    // Length writes land at once; the port never stalls.
    assign i_cfg.ready = 1'b1;

    // Sequencer: owns input ready and orders the datapath steps.
    dslg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath: hash, LCG, reduction and the output register that
    // decouples the result side from the sequencer.
    dslg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_in.in_byte),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_len   (i_cfg.out_length),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_char  (o_out.out_char),
        .o_out_last  (o_out.last)
    );

endmodule
`default_nettype wire
